FILE: rtl/core/hpar_pkg.sv
// Shared types and constants for the handle pool with age replacement.
// Used by every module under rtl/core; depends on nothing else.
package hpar_pkg;

	localparam int POOL_ENTRIES = 8;
	localparam int KEY_W        = 32;
	localparam int HANDLE_W     = 16;
	localparam int AGE_W        = 32;
	localparam int IDX_W        = $clog2(POOL_ENTRIES);
	localparam int CMD_W        = 2;

	// stream widths: input tdata = {handle_id, owner_key}, output tdata = handle_out
	localparam int IN_TDATA_W  = ((KEY_W + HANDLE_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((HANDLE_W + 7) / 8) * 8;
	localparam int OUT_TUSER_W = 2;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_ENTRIES - 1);

	typedef enum logic [CMD_W-1:0] {
		CMD_GET      = 2'd0,
		CMD_RELEASE  = 2'd1,
		CMD_FREE_KEY = 2'd2,
		CMD_FREE_ALL = 2'd3
	} cmd_t;

	typedef struct packed {
		logic                full;
		logic [KEY_W-1:0]    key;
		logic [HANDLE_W-1:0] handle;
		logic [AGE_W-1:0]    age;
	} entry_t;

	typedef struct packed {
		logic                clr;
		logic                fill;
		logic [IDX_W-1:0]    idx;
		logic [KEY_W-1:0]    key;
		logic [HANDLE_W-1:0] handle;
		logic [AGE_W-1:0]    age;
	} pool_wr_t;

	typedef struct packed {
		logic [KEY_W-1:0] key_a;
		logic [KEY_W-1:0] key_b;
		logic [AGE_W-1:0] age_a;
		logic [AGE_W-1:0] age_b;
	} cmp_req_t;

	typedef struct packed {
		logic key_eq;
		logic age_lt;
	} cmp_rsp_t;

endpackage

FILE: rtl/core/handle_pool_age_replacement_unit.sv
// Handle pool with age replacement, top level. One command per transfer; the
// sequencer scans the pool one entry a cycle, while the output register can
// take a result, through a shared compare unit. Input ready only while idle,
// so a new command waits until the previous one is done. Asynchronous
// active-low reset empties the pool and zeroes the age counter; no clearing
// pass is needed.
module handle_pool_age_replacement_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [hpar_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // owner_key, handle_id
	input  logic [hpar_pkg::CMD_W-1:0]           s_axis_tuser,  // cmd
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [hpar_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // handle_out
	output logic [hpar_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,  // hit, handle_valid
	output logic                                 m_axis_tlast
);
	import hpar_pkg::*;

	logic [IDX_W-1:0] rd_idx;
	entry_t           rd_entry;
	pool_wr_t         wr;
	cmp_req_t         cmp_req;
	cmp_rsp_t         cmp_rsp;

	hpar_pool u_pool (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_idx   (rd_idx),
		.rd_entry (rd_entry),
		.wr       (wr)
	);

	hpar_cmp u_cmp (
		.req (cmp_req),
		.rsp (cmp_rsp)
	);

	hpar_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.rd_idx        (rd_idx),
		.rd_entry      (rd_entry),
		.wr            (wr),
		.cmp_req       (cmp_req),
		.cmp_rsp       (cmp_rsp)
	);

endmodule

FILE: rtl/core/hpar_pool.sv
// Entry storage of the handle pool: full bits, keys, handles and ages.
// One read index, one write port. Depends on hpar_pkg.
module hpar_pool (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [hpar_pkg::IDX_W-1:0]   rd_idx,
	output hpar_pkg::entry_t             rd_entry,
	input  hpar_pkg::pool_wr_t           wr
);
	import hpar_pkg::*;

	logic [POOL_ENTRIES-1:0] full_q;
	logic [KEY_W-1:0]        key_q    [POOL_ENTRIES];
	logic [HANDLE_W-1:0]     handle_q [POOL_ENTRIES];
	logic [AGE_W-1:0]        age_q    [POOL_ENTRIES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= '0;
		end else if (wr.fill) begin
			full_q[wr.idx] <= 1'b1;
		end else if (wr.clr) begin
			full_q[wr.idx] <= 1'b0;
		end
	end

	// payload is only looked at behind a set full bit
	always_ff @(posedge clk) begin
		if (wr.fill) begin
			key_q[wr.idx]    <= wr.key;
			handle_q[wr.idx] <= wr.handle;
			age_q[wr.idx]    <= wr.age;
		end
	end

	always_comb begin
		rd_entry.full   = full_q[rd_idx];
		rd_entry.key    = key_q[rd_idx];
		rd_entry.handle = handle_q[rd_idx];
		rd_entry.age    = age_q[rd_idx];
	end

endmodule

FILE: rtl/core/hpar_cmp.sv
// Shared compare unit: key equality and unsigned age less-than.
// Reused on every scan step by the sequencer. Depends on hpar_pkg.
module hpar_cmp (
	input  hpar_pkg::cmp_req_t req,
	output hpar_pkg::cmp_rsp_t rsp
);
	import hpar_pkg::*;

	always_comb begin
		rsp.key_eq = (req.key_a == req.key_b);
		rsp.age_lt = (req.age_a < req.age_b);
	end

endmodule

FILE: rtl/core/hpar_seq.sv
// Command sequencer: walks the pool one entry a cycle unless back-pressure
// holds it; drives pool write port and output register. Needs hpar_pkg.
module hpar_seq (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [hpar_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	input  logic [hpar_pkg::CMD_W-1:0]           s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [hpar_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	output logic [hpar_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,
	output logic                                 m_axis_tlast,
	output logic [hpar_pkg::IDX_W-1:0]           rd_idx,
	input  hpar_pkg::entry_t                     rd_entry,
	output hpar_pkg::pool_wr_t                   wr,
	output hpar_pkg::cmp_req_t                   cmp_req,
	input  hpar_pkg::cmp_rsp_t                   cmp_rsp
);
	import hpar_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EVICT,
		ST_FLUSH
	} state_t;

	state_t              state_q;
	cmd_t                cmd_q;
	logic [KEY_W-1:0]    key_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [IDX_W-1:0]    idx_q;
	logic [IDX_W-1:0]    best_idx_q;
	logic [AGE_W-1:0]    best_age_q;
	logic [HANDLE_W-1:0] best_handle_q;
	logic                pend_q;
	logic [HANDLE_W-1:0] pend_handle_q;
	logic [AGE_W-1:0]    age_ctr_q;
	logic                out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;
	logic [OUT_TUSER_W-1:0] out_user_q;
	logic                out_last_q;

	logic                match_get;
	logic                match_free;
	logic                at_end;
	logic                out_free;
	logic                want_emit;
	logic                advance;
	logic                emit;
	logic                e_hit;
	logic                e_valid;
	logic [HANDLE_W-1:0] e_handle;
	logic                e_last;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;
	assign m_axis_tlast  = out_last_q;
	assign rd_idx        = idx_q;

	always_comb begin
		cmp_req.key_a = rd_entry.key;
		cmp_req.key_b = key_q;
		cmp_req.age_a = rd_entry.age;
		cmp_req.age_b = best_age_q;
	end

	assign match_get  = rd_entry.full && cmp_rsp.key_eq;
	assign match_free = rd_entry.full && ((cmd_q == CMD_FREE_ALL) || cmp_rsp.key_eq);
	assign at_end     = (idx_q == LAST_IDX);
	assign out_free   = !out_valid_q || m_axis_tready;

	always_comb begin
		want_emit = 1'b0;
		e_hit     = 1'b0;
		e_valid   = 1'b0;
		e_handle  = '0;
		e_last    = 1'b0;
		wr.clr    = 1'b0;
		wr.fill   = 1'b0;
		wr.idx    = idx_q;
		wr.key    = key_q;
		wr.handle = handle_q;
		wr.age    = age_ctr_q + AGE_W'(1);
		unique case (state_q)
			ST_SCAN: begin
				unique case (cmd_q)
					CMD_GET: begin
						if (match_get) begin
							want_emit = 1'b1;
							e_hit     = 1'b1;
							e_valid   = 1'b1;
							e_handle  = rd_entry.handle;
							e_last    = 1'b1;
							wr.clr    = 1'b1;
						end else if (at_end) begin
							want_emit = 1'b1;
							e_last    = 1'b1;
						end
					end
					CMD_RELEASE: begin
						if (!rd_entry.full) begin
							want_emit = 1'b1;
							e_last    = 1'b1;
							wr.fill   = 1'b1;
						end
					end
					CMD_FREE_KEY, CMD_FREE_ALL: begin
						// hold one freed handle back so the final one can carry last
						if (match_free) begin
							wr.clr = 1'b1;
							if (pend_q) begin
								want_emit = 1'b1;
								e_valid   = 1'b1;
								e_handle  = pend_handle_q;
							end
						end
					end
				endcase
			end
			ST_EVICT: begin
				want_emit = 1'b1;
				e_valid   = 1'b1;
				e_handle  = best_handle_q;
				e_last    = 1'b1;
				wr.fill   = 1'b1;
				wr.idx    = best_idx_q;
			end
			ST_FLUSH: begin
				want_emit = 1'b1;
				e_valid   = pend_q;
				e_handle  = pend_q ? pend_handle_q : '0;
				e_last    = 1'b1;
			end
			default: ;
		endcase
		advance = !want_emit || out_free;
		emit    = want_emit && advance;
		if (!advance) begin
			wr.clr  = 1'b0;
			wr.fill = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cmd_q         <= CMD_GET;
			key_q         <= '0;
			handle_q      <= '0;
			idx_q         <= '0;
			best_idx_q    <= '0;
			best_age_q    <= '0;
			best_handle_q <= '0;
			pend_q        <= 1'b0;
			pend_handle_q <= '0;
			age_ctr_q     <= '0;
			out_valid_q   <= 1'b0;
			out_data_q    <= '0;
			out_user_q    <= '0;
			out_last_q    <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				out_data_q  <= OUT_TDATA_W'(e_handle);
				out_user_q  <= {e_valid, e_hit};
				out_last_q  <= e_last;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						cmd_q    <= cmd_t'(s_axis_tuser);
						key_q    <= s_axis_tdata[KEY_W-1:0];
						handle_q <= s_axis_tdata[KEY_W +: HANDLE_W];
						idx_q    <= '0;
						pend_q   <= 1'b0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (advance) begin
						unique case (cmd_q)
							CMD_GET: begin
								if (match_get || at_end) begin
									state_q <= ST_IDLE;
								end else begin
									idx_q <= idx_q + IDX_W'(1);
								end
							end
							CMD_RELEASE: begin
								if (!rd_entry.full) begin
									age_ctr_q <= age_ctr_q + AGE_W'(1);
									state_q   <= ST_IDLE;
								end else begin
									// strict less-than keeps the lowest index on a tie
									if ((idx_q == '0) || cmp_rsp.age_lt) begin
										best_idx_q    <= idx_q;
										best_age_q    <= rd_entry.age;
										best_handle_q <= rd_entry.handle;
									end
									if (at_end) begin
										state_q <= ST_EVICT;
									end else begin
										idx_q <= idx_q + IDX_W'(1);
									end
								end
							end
							CMD_FREE_KEY, CMD_FREE_ALL: begin
								if (match_free) begin
									pend_q        <= 1'b1;
									pend_handle_q <= rd_entry.handle;
								end
								if (at_end) begin
									state_q <= ST_FLUSH;
								end else begin
									idx_q <= idx_q + IDX_W'(1);
								end
							end
						endcase
					end
				end
				ST_EVICT: begin
					if (advance) begin
						age_ctr_q <= age_ctr_q + AGE_W'(1);
						state_q   <= ST_IDLE;
					end
				end
				ST_FLUSH: begin
					if (advance) begin
						pend_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: verif/hpar_pool_checker.sv
// Checker for the handle pool: watches both stream channels, models the pool and
// compares every output transfer against the predicted result. Needs hpar_pkg.
`timescale 1ns / 100ps

module hpar_pool_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	input  logic [hpar_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic [hpar_pkg::CMD_W-1:0]       s_tuser,
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic [hpar_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic [hpar_pkg::OUT_TUSER_W-1:0] m_tuser,
	input  logic                             m_tlast,
	output int                               mismatch_count,
	output int                               results_due
);
	import hpar_pkg::*;

	typedef struct packed {
		logic                hit;
		logic                hvalid;
		logic [HANDLE_W-1:0] handle;
		logic                last;
	} pool_result_t;

	logic                pool_full   [POOL_ENTRIES];
	logic [KEY_W-1:0]    pool_key    [POOL_ENTRIES];
	logic [HANDLE_W-1:0] pool_handle [POOL_ENTRIES];
	logic [AGE_W-1:0]    pool_age    [POOL_ENTRIES];
	logic [AGE_W-1:0]    age_ctr;
	pool_result_t        due_q[$];

	initial begin
		mismatch_count = 0;
		results_due    = 0;
	end

	task automatic clear_slot(input int i);
		pool_full[i]   = 1'b0;
		pool_key[i]    = '0;
		pool_handle[i] = '0;
		pool_age[i]    = '0;
	endtask

	// appends one predicted result at the tail of the queue
	task automatic queue_result(input pool_result_t res);
		due_q.insert(due_q.size(), res);
	endtask

	task automatic apply_pool_cmd(input cmd_t op, input logic [KEY_W-1:0] key,
			input logic [HANDLE_W-1:0] hid);
		int           slot;
		int           oldest;
		logic [AGE_W-1:0] min_age;
		pool_result_t r;
		pool_result_t prev;
		bit           have_prev;
		bit           done;

		r = '{hit: 1'b0, hvalid: 1'b0, handle: '0, last: 1'b1};
		done = 1'b0;
		have_prev = 1'b0;
		prev = r;
		slot = -1;
		oldest = 0;
		min_age = '0;
		case (op)
			CMD_GET: begin
				for (int i = 0; i < POOL_ENTRIES; i++) begin
					if (!done && pool_full[i] && pool_key[i] == key) begin
						// only the valid bit goes; key, handle and age stay
						pool_full[i] = 1'b0;
						r.hit    = 1'b1;
						r.hvalid = 1'b1;
						r.handle = pool_handle[i];
						done     = 1'b1;
					end
				end
				queue_result(r);
			end
			CMD_RELEASE: begin
				for (int i = 0; i < POOL_ENTRIES; i++) begin
					if (slot < 0) begin
						if (!pool_full[i])
							slot = i;
						else if (i == 0 || pool_age[i] < min_age) begin
							min_age = pool_age[i];
							oldest  = i;
						end
					end
				end
				if (slot < 0) begin
					slot     = oldest;
					r.hvalid = 1'b1;
					r.handle = pool_handle[slot];
				end
				age_ctr           = age_ctr + 1'b1;
				pool_full[slot]   = 1'b1;
				pool_key[slot]    = key;
				pool_handle[slot] = hid;
				pool_age[slot]    = age_ctr;
				queue_result(r);
			end
			default: begin
				for (int i = 0; i < POOL_ENTRIES; i++) begin
					if (pool_full[i] && (op == CMD_FREE_ALL || pool_key[i] == key)) begin
						if (have_prev)
							queue_result(prev);
						prev = '{hit: 1'b0, hvalid: 1'b1, handle: pool_handle[i], last: 1'b0};
						have_prev = 1'b1;
						clear_slot(i);
					end
				end
				if (have_prev) begin
					prev.last = 1'b1;
					queue_result(prev);
				end else
					queue_result(r);
			end
		endcase
	endtask

	task automatic cmp_field(input string name, input logic [HANDLE_W-1:0] want,
			input logic [HANDLE_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h actual %0h", name, want, got);
			mismatch_count++;
		end
	endtask

	task automatic check_result(input pool_result_t got);
		pool_result_t want;

		if (due_q.size() == 0) begin
			$error("unexpected result transfer: handle_out %0h last %0b", got.handle, got.last);
			mismatch_count++;
		end else begin
			want = due_q.pop_front();
			cmp_field("hit", HANDLE_W'(want.hit), HANDLE_W'(got.hit));
			cmp_field("handle_valid", HANDLE_W'(want.hvalid), HANDLE_W'(got.hvalid));
			cmp_field("handle_out", want.handle, got.handle);
			cmp_field("last", HANDLE_W'(want.last), HANDLE_W'(got.last));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < POOL_ENTRIES; i++)
				clear_slot(i);
			age_ctr = '0;
			due_q.delete();
			results_due = 0;
		end else begin
			if (s_tvalid && s_tready)
				apply_pool_cmd(cmd_t'(s_tuser), s_tdata[KEY_W-1:0], s_tdata[KEY_W +: HANDLE_W]);
			if (m_tvalid && m_tready)
				check_result('{hit: m_tuser[0], hvalid: m_tuser[1],
					handle: m_tdata[HANDLE_W-1:0], last: m_tlast});
			results_due = due_q.size();
		end
	end

endmodule

FILE: verif/tb_handle_pool_age_replacement_unit.sv
// Testbench top for handle_pool_age_replacement_unit: drives commands with random
// gaps and back-pressure, and gives the verdict from hpar_pool_checker. Needs hpar_pkg.
`timescale 1ns / 100ps

module tb_handle_pool_age_replacement_unit;
	import hpar_pkg::*;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic [CMD_W-1:0]       s_tuser = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [OUT_TUSER_W-1:0] m_tuser;
	logic                   m_tlast;

	int mismatch_count;
	int results_due;

	bit gaps_on = 1'b1;
	bit stall_go = 1'b0;
	int stall_left = 0;
	logic [KEY_W-1:0] key_set [6];

	handle_pool_age_replacement_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_tvalid),
		.s_axis_tready(s_tready),
		.s_axis_tdata (s_tdata),   // owner_key, handle_id
		.s_axis_tuser (s_tuser),   // cmd
		.m_axis_tvalid(m_tvalid),
		.m_axis_tready(m_tready),
		.m_axis_tdata (m_tdata),   // handle_out
		.m_axis_tuser (m_tuser),   // hit, handle_valid
		.m_axis_tlast (m_tlast)
	);

	hpar_pool_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.m_tlast       (m_tlast),
		.mismatch_count(mismatch_count),
		.results_due   (results_due)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#5ms;
		$display("TB_ERROR");
		$finish;
	end

	// result side: random back-pressure, plus a long hold when the sender asks
	initial begin
		forever begin
			@(posedge clk);
			if (stall_go) begin
				stall_go   = 1'b0;
				stall_left = 300;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else
				m_tready <= !gaps_on || $urandom_range(0, 99) >= 25;
		end
	end

	task automatic offer_cmd(input cmd_t op, input logic [KEY_W-1:0] key,
			input logic [HANDLE_W-1:0] hid);
		while (gaps_on && $urandom_range(0, 99) < 25) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_TDATA_W'({hid, key});
		s_tuser  <= op;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// sampled at the falling edge so the checker has settled
	task automatic wait_pool_drained();
		s_tvalid <= 1'b0;
		do
			@(negedge clk);
		while (results_due != 0);
		@(posedge clk);
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		if ($urandom_range(0, 99) < 8)
			return $urandom();
		return key_set[$urandom_range(0, 5)];
	endfunction

	function automatic logic [HANDLE_W-1:0] pick_handle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return '0;
		if (r < 10)
			return '1;
		return HANDLE_W'($urandom_range(0, 65535));
	endfunction

	initial begin
		int r;
		cmd_t op;

		key_set[0] = '0;
		key_set[1] = '1;
		for (int i = 2; i < 6; i++)
			key_set[i] = $urandom();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty pool: misses and frees with nothing to free
		offer_cmd(CMD_GET, '0, '0);
		offer_cmd(CMD_FREE_KEY, '1, '0);
		offer_cmd(CMD_FREE_ALL, '0, '0);
		// handle zero round trip, then the emptied entry must not hit again
		offer_cmd(CMD_RELEASE, '0, '0);
		offer_cmd(CMD_GET, '0, '0);
		offer_cmd(CMD_GET, '0, '0);
		// fill the pool, then two evictions by oldest age
		for (int i = 0; i < 10; i++)
			offer_cmd(CMD_RELEASE, i[0] ? '0 : '1, i[0] ? HANDLE_W'(i) : '1);
		offer_cmd(CMD_GET, '1, '0);
		offer_cmd(CMD_RELEASE, 32'h5a5a_a5a5, 16'h1234);
		offer_cmd(CMD_FREE_KEY, '0, '0);
		offer_cmd(CMD_FREE_KEY, 32'h0bad_f00d, '0);
		offer_cmd(CMD_FREE_ALL, '0, '0);
		wait_pool_drained();

		for (int n = 0; n < 420; n++) begin
			if (n == 80 || n == 350)
				stall_go = 1'b1;
			if (n == 160 || n == 300)
				wait_pool_drained();
			gaps_on = !(n >= 220 && n < 300);
			r = $urandom_range(0, 99);
			if (r < 42)
				op = CMD_RELEASE;
			else if (r < 80)
				op = CMD_GET;
			else if (r < 93)
				op = CMD_FREE_KEY;
			else
				op = CMD_FREE_ALL;
			offer_cmd(op, pick_key(), pick_handle());
		end
		gaps_on = 1'b1;
		wait_pool_drained();
		repeat (12) @(posedge clk);

		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/hpar_pkg.sv
rtl/core/hpar_pool.sv
rtl/core/hpar_cmp.sv
rtl/core/hpar_seq.sv
rtl/core/handle_pool_age_replacement_unit.sv
verif/hpar_pool_checker.sv
verif/tb_handle_pool_age_replacement_unit.sv
